/* design/base64_packet_deframer_unit_assert.svh */
// Assertion macros for the base64 packet deframer.
// Used by base64_packet_deframer_unit; expects clk and rst in scope.
`ifndef BASE64_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define BASE64_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define B64PD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64_packet_deframer_unit: assertion failed");

// next-cycle implication
`define B64PD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64_packet_deframer_unit: assertion failed");

`endif

/* design/b64pd_pkg.sv */
// Shared types and constants for the base64 packet deframer.
// No dependencies.
`default_nettype none

package b64pd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_CSUM,
    ST_DROP
  } parse_state_t;

  typedef enum logic [1:0] {
    OP_BYTES,
    OP_HEART,
    OP_END,
    OP_RESEED
  } op_t;

  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_ACCEPT   = 3'd1;
  localparam logic [2:0] KIND_MISMATCH = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW = 3'd3;
  localparam logic [2:0] KIND_HEART    = 3'd4;

  localparam logic [23:0] SUM_SEED = 24'hDEBB1E;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int QDEPTH = 4;

  // one command per transaction that has work for the back end
  typedef struct packed {
    op_t         op;
    logic [23:0] stage;
    logic [1:0]  nfit;
    logic        ovf;
    logic [31:0] rx_sum;
  } cmd_t;

endpackage

`default_nettype wire

/* design/b64pd_front.sv */
// Front end: accepts characters, runs the frame parser, decodes groups.
// Depends on b64pd_pkg; pushes cmd_t entries into b64pd_queue.
`default_nettype none

module b64pd_front import b64pd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_char,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            cmd
);

  localparam int CW = ($clog2(MAX_PAYLOAD + 1) < 9) ? 9 : $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PAYLOAD);

  function automatic logic is_b64(input logic [7:0] ch);
    return ch inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], CH_PLUS, CH_SLASH, CH_EQ};
  endfunction

  function automatic logic [5:0] b64_value(input logic [7:0] ch);
    logic [5:0] v;
    v = 6'd0;
    if (ch inside {[8'h41:8'h5A]}) v = 6'(ch - 8'h41);
    else if (ch inside {[8'h61:8'h7A]}) v = 6'(ch - 8'd71);
    else if (ch inside {[8'h30:8'h39]}) v = 6'(ch + 8'd4);
    else if (ch == CH_PLUS) v = 6'd62;
    else if (ch == CH_SLASH) v = 6'd63;
    return v;
  endfunction

  parse_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   rx_sum, rx_sum_next;
  logic [7:0]    g0, g1, g2;
  logic          we0, we1, we2;

  logic          accept;
  logic          e0, e1, e2, e3;
  logic          grp_bad, grp_empty;
  logic [1:0]    nbytes, nfit;
  logic [CW-1:0] room;
  logic          ovf;
  logic [23:0]   stage;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign e0 = (g0 == CH_EQ);
  assign e1 = (g1 == CH_EQ);
  assign e2 = (g2 == CH_EQ);
  assign e3 = (rx_char == CH_EQ);
  assign grp_bad   = (e0 && !e1) || (e1 && !e2) || (e2 && !e3) || (!e0 && e1);
  assign grp_empty = e0;
  assign nbytes    = e2 ? 2'd1 : (e3 ? 2'd2 : 2'd3);
  assign stage     = {b64_value(g0), b64_value(g1), b64_value(g2), b64_value(rx_char)};
  assign room      = MAX_C - count;
  assign ovf       = room < CW'(nbytes);
  assign nfit      = ovf ? room[1:0] : nbytes;

  always_comb begin
    state_next  = state;
    count_next  = count;
    rx_sum_next = rx_sum;
    we0 = 1'b0;
    we1 = 1'b0;
    we2 = 1'b0;
    push = 1'b0;
    cmd.op     = OP_RESEED;
    cmd.stage  = stage;
    cmd.nfit   = nfit;
    cmd.ovf    = ovf;
    cmd.rx_sum = rx_sum;
    if (accept) begin
      if (rx_char <= CH_SPACE) begin
        state_next = state;
      end else if (rx_char == CH_STAR) begin
        push   = 1'b1;
        cmd.op = OP_HEART;
      end else if (rx_char == CH_LT) begin
        count_next = '0;
        state_next = ST_G0;
        push       = 1'b1;
        cmd.op     = OP_RESEED;
      end else begin
        case (state)
          ST_G0: begin
            if (is_b64(rx_char)) begin
              we0 = 1'b1;
              state_next = ST_G1;
            end else if (rx_char == CH_HASH) begin
              rx_sum_next = '0;
              state_next  = ST_CSUM;
            end else begin
              state_next = ST_DROP;
            end
          end
          ST_G1: begin
            if (is_b64(rx_char)) begin
              we1 = 1'b1;
              state_next = ST_G2;
            end else begin
              state_next = ST_DROP;
            end
          end
          ST_G2: begin
            if (is_b64(rx_char)) begin
              we2 = 1'b1;
              state_next = ST_G3;
            end else begin
              state_next = ST_DROP;
            end
          end
          ST_G3: begin
            if (!is_b64(rx_char) || grp_bad) begin
              state_next = ST_DROP;
            end else if (grp_empty) begin
              state_next = ST_G0;
            end else begin
              push       = 1'b1;
              cmd.op     = OP_BYTES;
              count_next = count + CW'(nfit);
              state_next = ovf ? ST_DROP : ST_G0;
            end
          end
          ST_CSUM: begin
            if (is_b64(rx_char)) begin
              rx_sum_next = {rx_sum[25:0], b64_value(rx_char)};
            end else if (rx_char == CH_GT) begin
              push       = 1'b1;
              cmd.op     = OP_END;
              count_next = '0;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_DROP;
            end
          end
          ST_DROP: begin
            if (rx_char == CH_GT) begin
              push       = 1'b1;
              cmd.op     = OP_RESEED;
              count_next = '0;
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rx_sum <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rx_sum <= rx_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) g0 <= rx_char;
    if (we1) g1 <= rx_char;
    if (we2) g2 <= rx_char;
  end

endmodule

`default_nettype wire

/* design/b64pd_queue.sv */
// Short command queue between the parser front end and the result back end.
// Depends on b64pd_pkg (cmd_t, QDEPTH).
`default_nettype none

module b64pd_queue import b64pd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(QDEPTH);
  localparam int FW = $clog2(QDEPTH + 1);

  cmd_t            entries [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [FW-1:0]   fill, fill_next;

  assign head  = entries[rd_ptr];
  assign full  = (fill == FW'(QDEPTH));
  assign empty = (fill == '0);

  always_comb begin
    fill_next = fill;
    if (push && !pop) fill_next = fill + FW'(1);
    else if (pop && !push) fill_next = fill - FW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule

`default_nettype wire

/* design/b64pd_back.sv */
// Back end: expands queued commands into result transactions, keeps checksum.
// Depends on b64pd_pkg; reads the head of b64pd_queue.
`default_nettype none

module b64pd_back import b64pd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       data_byte,
  output logic [8:0]       byte_count,
  output logic [23:0]      computed_sum,
  output logic [31:0]      received_sum,
  output logic             last
);

  localparam int CW = ($clog2(MAX_PAYLOAD + 1) < 9) ? 9 : $clog2(MAX_PAYLOAD + 1);

  logic [23:0]   sum, sum_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    idx, idx_next;

  logic          out_free, emit;
  logic [2:0]    r_kind;
  logic [7:0]    r_byte;
  logic [CW-1:0] r_count;
  logic [23:0]   r_sum;
  logic          r_last;
  logic [7:0]    cur_byte;
  logic [23:0]   sum_upd;
  logic          byte_last;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (idx)
      2'd0:    cur_byte = head.stage[23:16];
      2'd1:    cur_byte = head.stage[15:8];
      default: cur_byte = head.stage[7:0];
    endcase
  end

  assign sum_upd   = {sum[4:0], sum[23:5]} ^ {{16{cur_byte[7]}}, cur_byte};
  assign byte_last = (2'(idx + 2'd1) == head.nfit) && !head.ovf;

  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    sum_next   = sum;
    count_next = count;
    idx_next   = idx;
    r_kind     = KIND_DATA;
    r_byte     = 8'h00;
    r_count    = count;
    r_sum      = sum;
    r_last     = 1'b1;
    if (head_valid) begin
      case (head.op)
        OP_RESEED: begin
          pop        = 1'b1;
          sum_next   = SUM_SEED;
          count_next = '0;
        end
        OP_HEART: begin
          if (out_free) begin
            emit   = 1'b1;
            pop    = 1'b1;
            r_kind = KIND_HEART;
          end
        end
        OP_END: begin
          if (out_free) begin
            emit       = 1'b1;
            pop        = 1'b1;
            r_kind     = ({8'h00, sum} == head.rx_sum) ? KIND_ACCEPT : KIND_MISMATCH;
            sum_next   = SUM_SEED;
            count_next = '0;
          end
        end
        OP_BYTES: begin
          if (out_free) begin
            emit = 1'b1;
            if (idx < head.nfit) begin
              r_kind     = KIND_DATA;
              r_byte     = cur_byte;
              r_count    = count + CW'(1);
              r_sum      = sum_upd;
              r_last     = byte_last;
              count_next = count + CW'(1);
              sum_next   = sum_upd;
              if (byte_last) begin
                pop      = 1'b1;
                idx_next = 2'd0;
              end else begin
                idx_next = 2'(idx + 2'd1);
              end
            end else begin
              r_kind   = KIND_OVERFLOW;
              pop      = 1'b1;
              idx_next = 2'd0;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= SUM_SEED;
      count     <= '0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      sum   <= sum_next;
      count <= count_next;
      idx   <= idx_next;
      if (out_free) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      kind         <= r_kind;
      data_byte    <= r_byte;
      byte_count   <= r_count[8:0];
      computed_sum <= r_sum;
      received_sum <= head.rx_sum;
      last         <= r_last;
    end
  end

endmodule

`default_nettype wire

/* design/base64_packet_deframer_unit.sv */
// Base64 framed packet receiver: one character per cycle, results one per cycle, each
// while not stalled. With an empty queue an accepted character's command is queued and
// its first result then is registered at the output. Throughput: one character
// per cycle when the queue has room; a group of four gives up to three results,
// drained one per unstalled cycle by the back end behind a four-entry command queue.
// Reset (synchronous): parser idle, counts cleared, checksum seeded, queue empty.
`default_nettype none
`include "base64_packet_deframer_unit_assert.svh"

module base64_packet_deframer_unit import b64pd_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       data_byte,
  output logic [8:0]       byte_count,
  output logic [23:0]      computed_sum,
  output logic [31:0]      received_sum,
  output logic             last
);

  localparam logic [8:0] MAX_CNT9 = 9'(MAX_PAYLOAD);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t wr_cmd, head;

  b64pd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_char  (rx_char),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (wr_cmd)
  );

  b64pd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .pop    (q_pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64pd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (!q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .byte_count   (byte_count),
    .computed_sum (computed_sum),
    .received_sum (received_sum),
    .last         (last)
  );

  `B64PD_ASSERT_IMPL(a_push_room, q_push, !q_full)
  `B64PD_ASSERT_IMPL(a_pop_has_head, q_pop, !q_empty)
  `B64PD_ASSERT_IMPL(a_ovf_at_limit, out_valid && kind == KIND_OVERFLOW, byte_count == MAX_CNT9)
  `B64PD_ASSERT_IMPL(a_nondata_zero, out_valid && kind != KIND_DATA, data_byte == 8'h00)

endmodule

`default_nettype wire
